### rtl/aes_pkg.sv
// AES package: S-box tables, GF(2^8) helpers, request/result structs, states.
// Used by the AES block cipher modules except aes_ram; no dependencies.
`default_nettype none
package aes_pkg;

    localparam int KeyWordW = 64;
    localparam int CfgIdxW  = 3;
    localparam int RoundW   = 4;

    localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_KLEN = 3'd4;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    localparam logic ACT_ENCRYPT = 1'b0;

    typedef struct packed {
        logic        action;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_req_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } aes_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_KINIT,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;      // capture request, reset key schedule
        logic              kstep;     // produce next key word
        logic              kinit;     // first AddRoundKey
        logic              round;     // run one round
        logic [RoundW-1:0] rnd;       // round key to read for the next step (0..nr+1)
        logic              last;      // last round of this pass
    } aes_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [RoundW-1:0] nr;
        logic              action;
        logic              kexp_done;
    } aes_sts_t;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic logic [7:0] isbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        isbox = t[x];
    endfunction

endpackage : aes_pkg
`default_nettype wire

### rtl/aes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module aes_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule : aes_ram
`default_nettype wire

### rtl/aes_datapath.sv
// AES datapath: key expansion into a round-key RAM, state register and round unit.
// Depends on aes_pkg and aes_ram.
`default_nettype none
module aes_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire aes_pkg::aes_req_t  req,
    input  wire logic [63:0]        key0,
    input  wire logic [63:0]        key1,
    input  wire logic [63:0]        key2,
    input  wire logic [63:0]        key3,
    input  wire logic [1:0]         klen,
    input  wire aes_pkg::aes_cmd_t  cmd,
    output aes_pkg::aes_sts_t       sts,
    output aes_pkg::aes_res_t       res
);
    import aes_pkg::*;

    logic [127:0] st_reg, st_next;
    logic         act_reg;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   total;
    logic [5:0]   wi_reg, wi_next;
    logic [3:0]   mod_reg, mod_next;     // wi mod nk
    logic [7:0]   rcon_reg, rcon_next;
    logic [31:0]  win_reg [8];          // sliding window of last nk words
    logic [31:0]  wnew, t_rot, t_sub, tt, wprev, wback;
    logic [31:0]  kwin [8];
    logic         ram_we;
    logic [3:0]   ram_raddr;
    logic [127:0] ram_wdata;
    logic [127:0] ram_rdata;
    logic [127:0] rk_acc_reg;
    logic         rk_hit_reg;
    logic [127:0] rk_wdata_reg;
    logic [127:0] rk_word;

    assign nk    = (klen == KLEN_128) ? 4'd4 : (klen == KLEN_192) ? 4'd6 : 4'd8;
    assign nr    = nk + 4'd6;
    assign total = {nr, 2'b00} + 6'd4;

    assign kwin[0] = key0[63:32];
    assign kwin[1] = key0[31:0];
    assign kwin[2] = key1[63:32];
    assign kwin[3] = key1[31:0];
    assign kwin[4] = key2[63:32];
    assign kwin[5] = key2[31:0];
    assign kwin[6] = key3[63:32];
    assign kwin[7] = key3[31:0];

    // next key word from window: win_reg[0] is w[i-nk], win_reg[nk-1] is w[i-1]
    assign wprev = win_reg[nk[2:0] - 3'd1];
    assign wback = win_reg[0];
    assign t_rot = {wprev[23:0], wprev[31:24]};
    assign t_sub = {sbox(t_rot[31:24]), sbox(t_rot[23:16]), sbox(t_rot[15:8]),
                    sbox(t_rot[7:0])};
    always_comb
    begin
        if (mod_reg == 4'd0)
        begin
            tt = {t_sub[31:24] ^ rcon_reg, t_sub[23:0]};
        end
        else if ((nk == 4'd8) && (mod_reg == 4'd4))
        begin
            tt = {sbox(wprev[31:24]), sbox(wprev[23:16]), sbox(wprev[15:8]),
                  sbox(wprev[7:0])};
        end
        else
        begin
            tt = wprev;
        end
    end
    // words below nk come straight from the key registers
    assign wnew = (wi_reg < {2'b00, nk}) ? kwin[wi_reg[2:0]] : (wback ^ tt);

    always_comb
    begin
        wi_next   = wi_reg;
        mod_next  = mod_reg;
        rcon_next = rcon_reg;
        if (cmd.load)
        begin
            wi_next   = '0;
            mod_next  = '0;
            rcon_next = 8'h01;
        end
        else if (cmd.kstep)
        begin
            wi_next = wi_reg + 6'd1;
            if (wi_reg >= {2'b00, nk})
            begin
                mod_next = (mod_reg == nk - 4'd1) ? 4'd0 : mod_reg + 4'd1;
                if (mod_reg == 4'd0)
                begin
                    rcon_next = xt(rcon_reg);
                end
            end
        end
    end

    // advance key schedule counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg   <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else
        begin
            wi_reg   <= wi_next;
            mod_reg  <= mod_next;
            rcon_reg <= rcon_next;
        end
    end

    // shift window, gather four words into a round key
    always_ff @(posedge clk)
    begin
        if (cmd.kstep)
        begin
            if (wi_reg < {2'b00, nk})
            begin
                win_reg[wi_reg[2:0]] <= wnew;
            end
            else
            begin
                for (int i = 0; i < 7; i++)
                begin
                    if (i + 1 < int'(nk))
                    begin
                        win_reg[i] <= win_reg[i+1];
                    end
                end
                win_reg[nk[2:0] - 3'd1] <= wnew;
            end
            rk_acc_reg <= {rk_acc_reg[95:0], wnew};
        end
    end

    assign ram_we    = cmd.kstep && (wi_reg[1:0] == 2'd3);
    assign ram_wdata = {rk_acc_reg[95:0], wnew};

    // round key for next cycle: read address chosen by controller
    always_comb
    begin
        if (act_reg == ACT_ENCRYPT)
        begin
            ram_raddr = cmd.rnd;
        end
        else
        begin
            ram_raddr = nr - cmd.rnd;
        end
    end

    aes_ram #(.Width(128), .Depth(16)) u_rk (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg[5:2]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // forward a key written at the same edge it is read (last key for decrypt)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk_hit_reg <= 1'b0;
        end
        else
        begin
            rk_hit_reg <= ram_we && (wi_reg[5:2] == ram_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        rk_wdata_reg <= ram_wdata;
    end

    assign rk_word = rk_hit_reg ? rk_wdata_reg : ram_rdata;

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] a2, a4, a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        gm = (b[0] ? a : 8'h00) ^ (b[1] ? a2 : 8'h00) ^ (b[2] ? a4 : 8'h00)
           ^ (b[3] ? a8 : 8'h00);
    endfunction

    // round unit
    logic [7:0]   sb [16];
    logic [7:0]   sr [16];
    logic [7:0]   mx [16];
    logic [7:0]   ad [16];
    logic [7:0]   si [16];
    logic [7:0]   isr [16];
    logic [7:0]   isb [16];
    logic [7:0]   ak [16];
    logic [7:0]   imx [16];
    logic [127:0] enc_out, dec_out;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            si[i] = st_reg[127 - 8*i -: 8];
        end
        // encrypt: SubBytes, ShiftRows, MixColumns, AddRoundKey
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = sbox(si[i]);
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sr[r + 4*c] = sb[r + 4*((c + r) & 3)];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                mx[4*c + r] = xt(sr[4*c + r]) ^ xt(sr[4*c + ((r+1)&3)])
                            ^ sr[4*c + ((r+1)&3)] ^ sr[4*c + ((r+2)&3)]
                            ^ sr[4*c + ((r+3)&3)];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            ad[i] = (cmd.last ? sr[i] : mx[i]) ^ rk_word[127 - 8*i -: 8];
            enc_out[127 - 8*i -: 8] = ad[i];
        end
        // decrypt: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                isr[r + 4*((c + r) & 3)] = si[r + 4*c];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            isb[i] = isbox(isr[i]);
            ak[i]  = isb[i] ^ rk_word[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                imx[4*c + r] = gm(ak[4*c + r], 4'd14) ^ gm(ak[4*c + ((r+1)&3)], 4'd11)
                             ^ gm(ak[4*c + ((r+2)&3)], 4'd13)
                             ^ gm(ak[4*c + ((r+3)&3)], 4'd9);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dec_out[127 - 8*i -: 8] = cmd.last ? ak[i] : imx[i];
        end
    end

    // state register update
    always_comb
    begin
        st_next = st_reg;
        if (cmd.load)
        begin
            st_next = {req.block_high, req.block_low};
        end
        else if (cmd.kinit)
        begin
            st_next = st_reg ^ rk_word;
        end
        else if (cmd.round)
        begin
            st_next = (act_reg == ACT_ENCRYPT) ? enc_out : dec_out;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_ENCRYPT;
        end
        else if (cmd.load)
        begin
            act_reg <= req.action;
        end
    end

    assign sts.nr        = nr;
    assign sts.action    = act_reg;
    assign sts.kexp_done = cmd.kstep && (wi_reg == total - 6'd1);
    assign res.result_high = st_reg[127:64];
    assign res.result_low  = st_reg[63:0];
endmodule : aes_datapath
`default_nettype wire

### rtl/aes_ctrl.sv
// AES controller: sequences key expansion, initial key add and the rounds.
// Depends on aes_pkg.
`default_nettype none
module aes_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire aes_pkg::aes_sts_t  sts,
    output aes_pkg::aes_cmd_t       cmd,
    output logic                    busy,
    output logic                    done
);
    import aes_pkg::*;

    aes_state_t        state_reg, state_next;
    logic [RoundW-1:0] rnd_reg, rnd_next;

    // hold state and round count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    // next state and commands; the RAM read of a round's key is issued in the cycle before the round
    always_comb
    begin
        state_next  = state_reg;
        rnd_next    = rnd_reg;
        cmd         = '0;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_KEXP;
                end
            end
            ST_KEXP:
            begin
                cmd.kstep = 1'b1;
                if (sts.kexp_done)
                begin
                    state_next = ST_KINIT;
                end
            end
            ST_KINIT:
            begin
                // read of the first key (key 0, or key nr when decrypting) was issued by the last expansion cycle
                cmd.kinit  = 1'b1;
                cmd.rnd    = 4'd1;
                rnd_next   = 4'd1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                cmd.last  = (rnd_reg == sts.nr);
                cmd.rnd   = rnd_reg + 4'd1;
                rnd_next  = rnd_reg + 4'd1;
                if (rnd_reg == sts.nr)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule : aes_ctrl
`default_nettype wire

### rtl/aes_block_cipher.sv
// AES-128/192/256 block cipher top level: key registers, controller, datapath.
// Depends on aes_pkg, aes_ctrl, aes_datapath, aes_ram.
//
//  channel   handshake          payload
//  request   start / busy       req (action, block_high, block_low)
//  result    done strobe        res (result_high, result_low)
//  config    cfg_we             cfg_index, cfg_data
//
// Per block: key expansion of 4*(nr+1) words (one key word a cycle), the
// initial AddRoundKey, nr rounds through the shared round unit, then the
// result is presented. The controller then returns to idle, where it takes
// the next request; no new block is taken while one is in flight. The
// round-key RAM read port paces the rounds. Reset clears the key registers
// and the controller. The result is shown for one cycle on done; the
// receiver cannot stall.
`default_nettype none
module aes_block_cipher (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire aes_pkg::aes_req_t                req,
    output logic                                  busy,
    output logic                                  done,
    output aes_pkg::aes_res_t                     res,
    input  wire logic                             cfg_we,
    input  wire logic [aes_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [aes_pkg::KeyWordW-1:0]     cfg_data
);
    import aes_pkg::*;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [1:0]  klen_reg;
    logic [1:0]  klen_eff;
    aes_cmd_t    cmd;
    aes_sts_t    sts;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            klen_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY0: key0_reg <= cfg_data;
                REG_KEY1: key1_reg <= cfg_data;
                REG_KEY2: key2_reg <= cfg_data;
                REG_KEY3: key3_reg <= cfg_data;
                REG_KLEN: klen_reg <= cfg_data[1:0];
                default:  ;
            endcase
        end
    end

    // length code 3 acts as a 256-bit key
    assign klen_eff = (klen_reg == 2'd3) ? 2'd2 : klen_reg;

    aes_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    aes_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .key0  (key0_reg),
        .key1  (key1_reg),
        .key2  (key2_reg),
        .key3  (key3_reg),
        .klen  (klen_eff),
        .cmd   (cmd),
        .sts   (sts),
        .res   (res)
    );
endmodule : aes_block_cipher
`default_nettype wire

### test/testbench.sv
// Testbench for the AES block cipher: drives encrypt and decrypt requests under
// several key settings and checks each result against an in-bench cipher model.
// Depends on aes_pkg and aes_block_cipher.
`timescale 1ns / 1ps
module testbench;
    import aes_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    aes_req_t req;
    logic busy;
    logic done;
    aes_res_t res;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [KeyWordW-1:0] cfg_data;

    // local copy of the key registers
    logic [63:0] key_reg [4];
    logic [1:0] klen_reg;

    aes_res_t cipher_queue[$];
    int error_count;
    int send_idle_pct;

    aes_block_cipher dut (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
        .done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock, 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    // forward S-box from the field inverse and the affine map
    function automatic logic [7:0] fwd_sub(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] base;
        logic [7:0] y;
        inv = 8'h00;
        if (x != 8'h00)
        begin
            inv = 8'h01;
            base = x;
            for (int e = 0; e < 8; e++)
            begin
                if (e != 0)
                    inv = gf_mul(inv, base);
                base = gf_mul(base, base);
            end
        end
        y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return y;
    endfunction

    logic [7:0] sub_tab [256];
    logic [7:0] inv_sub_tab [256];

    // compute one block with the current key settings
    function automatic aes_res_t cipher_block(input aes_req_t r);
        logic [31:0] w [60];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] col [4];
        logic [31:0] tmp;
        logic [7:0] rcon;
        logic [7:0] v;
        int nk;
        int nr;
        aes_res_t o;
        nk = (klen_reg == 2'd0) ? 4 : (klen_reg == 2'd1) ? 6 : 8;
        nr = nk + 6;
        rcon = 8'h01;
        for (int i = 0; i < nk; i++)
            w[i] = (i & 1) ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = nk; i < 4 * (nr + 1); i++)
        begin
            tmp = w[i - 1];
            if (i % nk == 0)
            begin
                tmp = {tmp[23:0], tmp[31:24]};
                tmp = {sub_tab[tmp[31:24]] ^ rcon, sub_tab[tmp[23:16]],
                       sub_tab[tmp[15:8]], sub_tab[tmp[7:0]]};
                rcon = gf_dbl(rcon);
            end
            else if (nk > 6 && i % nk == 4)
                tmp = {sub_tab[tmp[31:24]], sub_tab[tmp[23:16]],
                       sub_tab[tmp[15:8]], sub_tab[tmp[7:0]]};
            w[i] = w[i - nk] ^ tmp;
        end
        for (int i = 0; i < 8; i++)
        begin
            s[i] = r.block_high[63 - 8 * i -: 8];
            s[8 + i] = r.block_low[63 - 8 * i -: 8];
        end
        if (r.action == ACT_ENCRYPT)
        begin
            for (int i = 0; i < 16; i++)
                s[i] ^= w[i / 4][31 - 8 * (i % 4) -: 8];
            for (int rd = 1; rd <= nr; rd++)
            begin
                for (int i = 0; i < 16; i++)
                    s[i] = sub_tab[s[i]];
                for (int rr = 0; rr < 4; rr++)
                    for (int c = 0; c < 4; c++)
                        t[rr + 4 * c] = s[rr + 4 * ((c + rr) & 3)];
                s = t;
                if (rd != nr)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int k = 0; k < 4; k++)
                            col[k] = s[4 * c + k];
                        for (int rr = 0; rr < 4; rr++)
                        begin
                            v = 8'h00;
                            for (int k = 0; k < 4; k++)
                                case ((k - rr + 4) & 3)
                                    0: v ^= gf_mul(8'd2, col[k]);
                                    1: v ^= gf_mul(8'd3, col[k]);
                                    default: v ^= col[k];
                                endcase
                            s[4 * c + rr] = v;
                        end
                    end
                for (int i = 0; i < 16; i++)
                    s[i] ^= w[4 * rd + i / 4][31 - 8 * (i % 4) -: 8];
            end
        end
        else
        begin
            for (int i = 0; i < 16; i++)
                s[i] ^= w[4 * nr + i / 4][31 - 8 * (i % 4) -: 8];
            for (int rd = nr - 1; rd >= 0; rd--)
            begin
                for (int rr = 0; rr < 4; rr++)
                    for (int c = 0; c < 4; c++)
                        t[rr + 4 * ((c + rr) & 3)] = s[rr + 4 * c];
                s = t;
                for (int i = 0; i < 16; i++)
                    s[i] = inv_sub_tab[s[i]] ^ w[4 * rd + i / 4][31 - 8 * (i % 4) -: 8];
                if (rd != 0)
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int k = 0; k < 4; k++)
                            col[k] = s[4 * c + k];
                        for (int rr = 0; rr < 4; rr++)
                        begin
                            v = 8'h00;
                            for (int k = 0; k < 4; k++)
                                case ((k - rr + 4) & 3)
                                    0: v ^= gf_mul(8'd14, col[k]);
                                    1: v ^= gf_mul(8'd11, col[k]);
                                    2: v ^= gf_mul(8'd13, col[k]);
                                    default: v ^= gf_mul(8'd9, col[k]);
                                endcase
                            s[4 * c + rr] = v;
                        end
                    end
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            o.result_high[63 - 8 * i -: 8] = s[i];
            o.result_low[63 - 8 * i -: 8] = s[8 + i];
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        aes_res_t want;
        if (rst_n && done)
        begin
            if (cipher_queue.size() == 0)
            begin
                report_mismatch("unexpected result", res.result_high, 64'd0);
            end
            else
            begin
                want = cipher_queue.pop_front();
                if (res.result_high !== want.result_high)
                    report_mismatch("result_high", res.result_high, want.result_high);
                if (res.result_low !== want.result_low)
                    report_mismatch("result_low", res.result_low, want.result_low);
            end
        end
    end

    // send one request and record its expected result
    task automatic send_request(input aes_req_t r);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cipher_queue.push_back(cipher_block(r));
        start <= 1'b0;
        @(posedge clk);
    endtask

    // write one register while idle
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KEY0: key_reg[0] = val;
            REG_KEY1: key_reg[1] = val;
            REG_KEY2: key_reg[2] = val;
            REG_KEY3: key_reg[3] = val;
            REG_KLEN: klen_reg = val[1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain_wait();
        while (cipher_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_key(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [63:0] klen);
        drain_wait();
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_KLEN, klen);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic aes_req_t rand_req();
        aes_req_t r;
        r.action = 1'($urandom_range(1));
        r.block_high = rand64();
        r.block_low = rand64();
        return r;
    endfunction

    // standard vectors, field extremes and every key length code
    task automatic test_directed();
        aes_req_t r;
        send_idle_pct = 0;
        // reset key: all zero, 128 bit
        r = '{action: 1'b0, block_high: '0, block_low: '0};
        send_request(r);
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, 64'h18191a1b1c1d1e1f, {62'd0, KLEN_128});
        r = '{action: 1'b0, block_high: 64'h0011223344556677, block_low: 64'h8899aabbccddeeff};
        send_request(r);
        r = '{action: 1'b1, block_high: 64'h69c4e0d86a7b0430, block_low: 64'hd8cdb78070b4c55a};
        send_request(r);
        for (int a = 0; a < 2; a++)
        begin
            r = '{action: a[0], block_high: '1, block_low: '1};
            send_request(r);
            r = '{action: a[0], block_high: '0, block_low: '1};
            send_request(r);
        end
        set_key(key_reg[0], key_reg[1], key_reg[2], key_reg[3], {62'd0, KLEN_192});
        r = '{action: 1'b0, block_high: 64'h0011223344556677, block_low: 64'h8899aabbccddeeff};
        send_request(r);
        r.action = 1'b1;
        send_request(r);
        set_key(key_reg[0], key_reg[1], key_reg[2], key_reg[3], 64'd2);
        r.action = 1'b0;
        send_request(r);
        r.action = 1'b1;
        send_request(r);
        // length code 3 acts as 256 bit; stray upper data bits dropped
        set_key('1, '1, '1, '1, 64'hffff_ffff_ffff_ffff);
        send_request(r);
        r.action = 1'b0;
        send_request(r);
        // index beyond the register list does nothing
        drain_wait();
        write_reg(3'd7, 64'h0123);
        write_reg(3'd5, 64'h0);
        send_request(r);
        set_key('0, '0, '0, '0, 64'd1);
        send_request(r);
    endtask

    task automatic test_random(input int pct, input int count);
        send_idle_pct = pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                set_key(rand64(), rand64(), rand64(), rand64(), 64'($urandom_range(3)));
            send_request(rand_req());
        end
    endtask

    // hold the sender until every result is back, then continue
    task automatic test_hold_off();
        send_idle_pct = 0;
        send_request(rand_req());
        drain_wait();
        send_request(rand_req());
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        send_idle_pct = 0;
        klen_reg = KLEN_128;
        for (int i = 0; i < 4; i++)
            key_reg[i] = '0;
        for (int i = 0; i < 256; i++)
        begin
            sub_tab[i] = fwd_sub(i[7:0]);
            inv_sub_tab[sub_tab[i]] = i[7:0];
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(7, 700);
        test_hold_off();
        test_random(51, 600);
        test_random(0, 700);
        drain_wait();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // overall time limit
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

### sim.f
rtl/aes_pkg.sv
rtl/aes_ram.sv
rtl/aes_datapath.sv
rtl/aes_ctrl.sv
rtl/aes_block_cipher.sv
test/testbench.sv
